[rtl/cdta_pkg.sv]
// ----------------------------------------------------------------------------
// cdta_pkg
// Shared constants and calendar helpers for the calendar date and time adder.
// ----------------------------------------------------------------------------
package cdta_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;

  // default width of the whole-hours field
  localparam int HOURS_WIDTH_DEF = 16;

  // calendar constants
  localparam int YEAR_MAX       = 9999;
  localparam int YEAR_SPAN      = 10000;
  localparam int YEAR_SKIP      = 400;
  localparam int DAYS_PER_400Y  = 146097;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int DAYS_PER_LEAP  = 366;
  localparam int HOURS_PER_DAY  = 24;
  localparam int MIN_PER_HOUR   = 60;
  localparam int CENT_FACTOR    = 25;

  // month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // reciprocal of 25 scaled by 2^20, exact for any 14-bit year
  localparam int RECIP25       = 41944;
  localparam int RECIP_W       = 16;
  localparam int RECIP_SHIFT   = 20;
  localparam int PROD_W        = YEAR_W + RECIP_W;
  localparam int QUOT25_W      = PROD_W - RECIP_SHIFT;

  // mod 25 remainder width
  localparam int R25_W = 5;

  // leap rule from the low year bits and the year mod 25
  function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                   input logic [R25_W-1:0] r25);
    logic div4;
    logic div16;
    div4  = (year[1:0] == 2'd0);
    div16 = (year[3:0] == 4'd0);
    return (div4 && (r25 != '0)) || (div16 && (r25 == '0));
  endfunction

  // days in a month, zero for a month code that names no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                        len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                     len = '0;
    endcase
    return len;
  endfunction

endpackage

[rtl/calendar_date_time_adder.sv]
// ----------------------------------------------------------------------------
// calendar_date_time_adder
// Adds a duration of whole hours plus minutes to a Gregorian date and time.
// One item is worked at a time; in_stall stays high from acceptance until
// its result is taken. An item passes through the setup steps (year mod 25, date
// check, reciprocal multiply for the split by 24, hour and day split), then
// through the calendar walk, one step per month crossed, per whole year
// skipped from January and per 400-year skip, plus a final step that sees
// the day fit its month, then waits in the output register until taken.
// A bad start date goes from the date check straight to the output register.
// Years wrap past 9999 to 0 and raise year_overflow; a 400-year skip wraps
// modulo 10000.
// ----------------------------------------------------------------------------
module calendar_date_time_adder #(
  parameter int HOURS_WIDTH = cdta_pkg::HOURS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdta_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [cdta_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [cdta_pkg::DAY_W-1:0]    in_start_day,
  input  logic [cdta_pkg::HOUR_W-1:0]   in_start_hour,
  input  logic [cdta_pkg::MINUTE_W-1:0] in_start_minute,
  input  logic [cdta_pkg::MINUTE_W-1:0] in_add_minutes,
  input  logic [HOURS_WIDTH-1:0]        in_add_hours,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdta_pkg::YEAR_W-1:0]   out_end_year,
  output logic [cdta_pkg::MONTH_W-1:0]  out_end_month,
  output logic [cdta_pkg::DAY_W-1:0]    out_end_day,
  output logic [cdta_pkg::HOUR_W-1:0]   out_end_hour,
  output logic [cdta_pkg::MINUTE_W-1:0] out_end_minute,
  output logic                          out_bad_date,
  output logic                          out_year_overflow
);

  localparam int YW  = cdta_pkg::YEAR_W;
  localparam int MW  = cdta_pkg::MONTH_W;
  localparam int DYW = cdta_pkg::DAY_W;
  localparam int HW  = cdta_pkg::HOUR_W;
  localparam int NW  = cdta_pkg::MINUTE_W;
  localparam int RW  = cdta_pkg::R25_W;
  // total hours and day count widths
  localparam int TW  = HOURS_WIDTH + 1;
  localparam int DW  = (TW > 18) ? TW : 18;
  // shared subtractor width, top bit is the borrow
  localparam int SW  = DW + 1;
  localparam int SUMW = NW + 1;
  // split by 24: total hours over 8, then times a reciprocal of 3
  localparam int QN       = TW - 3;
  localparam int QW       = TW - 4;
  localparam int R3_SHIFT = QN + 3;
  localparam int R3_W     = QN + 2;
  localparam longint unsigned RECIP3 = ((64'd1 << R3_SHIFT) + 64'd2) / 64'd3;
  // shared multiplier operand and product widths
  localparam int MA_W = (QN > YW) ? QN : YW;
  localparam int MB_W = (R3_W > cdta_pkg::RECIP_W) ? R3_W : cdta_pkg::RECIP_W;
  localparam int MULW = MA_W + MB_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DAYS  = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [YW-1:0]                 year_r, year_nxt;
  logic [MW-1:0]                 month_r, month_nxt;
  logic [DW-1:0]                 dday_r, dday_nxt;
  logic [HW-1:0]                 hour_r, hour_nxt;
  logic [NW-1:0]                 minute_r, minute_nxt;
  logic [NW-1:0]                 amin_r, amin_nxt;
  logic [HOURS_WIDTH-1:0]        ahours_r, ahours_nxt;
  logic [MULW-1:0]               prod_r, prod_nxt;
  logic [RW-1:0]                 r25_r, r25_nxt;
  logic [TW-1:0]                 thr_r, thr_nxt;
  logic                          bad_r, bad_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          accept;
  logic                          leap;
  logic [DYW-1:0]                mlen;
  logic [8:0]                    ylen;
  logic [cdta_pkg::QUOT25_W-1:0] q25;
  logic [YW-1:0]                 q25x;
  logic [YW-1:0]                 r25_full;
  logic [SUMW-1:0]               tmin;
  logic [1:0]                    mcarry;
  logic [SUMW-1:0]               tmin_rem;
  logic [MA_W-1:0]               mul_a;
  logic [MB_W-1:0]               mul_b;
  logic [MULW-1:0]               mul_p;
  logic [QW-1:0]                 q_day;
  logic [TW-1:0]                 q24;
  logic [TW-1:0]                 hrem;
  logic [SW-1:0]                 sub_a, sub_b, sub_d;
  logic                          in_jan;
  logic                          skip_400;
  logic                          skip_year;
  logic [YW-1:0]                 year_400;
  logic [YW-1:0]                 year_step;
  logic [RW-1:0]                 r25_step;
  logic                          ovf_step;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  // result fields come straight from the working registers
  assign out_end_year      = year_r;
  assign out_end_month     = month_r;
  assign out_end_day       = dday_r[DYW-1:0];
  assign out_end_hour      = hour_r;
  assign out_end_minute    = minute_r;
  assign out_bad_date      = bad_r;
  assign out_year_overflow = ovf_r;

  // shared multiplier: year reciprocal at accept, hours reciprocal afterwards
  always_comb begin
    if (state_r == S_IDLE) begin
      mul_a = MA_W'(in_start_year);
      mul_b = MB_W'(cdta_pkg::RECIP25);
    end else begin
      mul_a = MA_W'(thr_r[TW-1:3]);
      mul_b = MB_W'(RECIP3);
    end
  end
  assign mul_p = MULW'(mul_a) * MULW'(mul_b);

  // year mod 25 from the registered reciprocal product
  always_comb begin
    q25      = prod_r[cdta_pkg::PROD_W-1:cdta_pkg::RECIP_SHIFT];
    q25x     = (YW'(q25) << 4) + (YW'(q25) << 3) + YW'(q25);
    r25_full = year_r - q25x;
  end

  // whole days and leftover hours, 24 is 16 plus 8
  always_comb begin
    q_day = prod_r[R3_SHIFT+QW-1:R3_SHIFT];
    q24   = (TW'(q_day) << 4) + (TW'(q_day) << 3);
    hrem  = thr_r - q24;
  end

  // calendar facts for the current year and month
  assign leap = cdta_pkg::is_leap(year_r, r25_r);
  assign mlen = cdta_pkg::month_len(month_r, leap);
  assign ylen = leap ? 9'(cdta_pkg::DAYS_PER_LEAP) : 9'(cdta_pkg::DAYS_PER_YEAR);

  // minute sum and its carry into hours
  always_comb begin
    tmin = SUMW'(minute_r) + SUMW'(amin_r);
    if (tmin >= SUMW'(2 * cdta_pkg::MIN_PER_HOUR)) begin
      mcarry   = 2'd2;
      tmin_rem = tmin - SUMW'(2 * cdta_pkg::MIN_PER_HOUR);
    end else if (tmin >= SUMW'(cdta_pkg::MIN_PER_HOUR)) begin
      mcarry   = 2'd1;
      tmin_rem = tmin - SUMW'(cdta_pkg::MIN_PER_HOUR);
    end else begin
      mcarry   = 2'd0;
      tmin_rem = tmin;
    end
  end

  // walk branch selection
  assign in_jan    = (month_r == cdta_pkg::MONTH_JAN) && (year_r <= YW'(cdta_pkg::YEAR_MAX));
  assign skip_400  = in_jan && (dday_r > DW'(cdta_pkg::DAYS_PER_400Y));
  assign skip_year = in_jan && (dday_r > DW'(ylen));

  // shared subtractor: day count reduction
  assign sub_a = SW'(dday_r);
  always_comb begin
    priority if (skip_400) begin
      sub_b = SW'(cdta_pkg::DAYS_PER_400Y);
    end else if (skip_year) begin
      sub_b = SW'(ylen);
    end else begin
      sub_b = SW'(mlen);
    end
  end
  assign sub_d = sub_a - sub_b;

  // single year step with wrap
  always_comb begin
    if (year_r >= YW'(cdta_pkg::YEAR_MAX)) begin
      year_step = '0;
      r25_step  = '0;
      ovf_step  = 1'b1;
    end else begin
      year_step = year_r + YW'(1);
      r25_step  = (r25_r == RW'(cdta_pkg::CENT_FACTOR - 1)) ? '0 : r25_r + RW'(1);
      ovf_step  = ovf_r;
    end
  end

  // 400-year skip, wraps modulo 10000
  assign year_400 = year_r + YW'(cdta_pkg::YEAR_SKIP);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    dday_nxt   = dday_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    amin_nxt   = amin_r;
    ahours_nxt = ahours_r;
    prod_nxt   = prod_r;
    r25_nxt    = r25_r;
    thr_nxt    = thr_r;
    bad_nxt    = bad_r;
    ovf_nxt    = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          year_nxt   = in_start_year;
          month_nxt  = in_start_month;
          dday_nxt   = DW'(in_start_day);
          hour_nxt   = in_start_hour;
          minute_nxt = in_start_minute;
          amin_nxt   = in_add_minutes;
          ahours_nxt = in_add_hours;
          prod_nxt   = mul_p;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        r25_nxt   = r25_full[RW-1:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ovf_nxt = 1'b0;
        if ((month_r == '0) || (month_r > cdta_pkg::MONTH_DEC) ||
            (dday_r == '0) || (dday_r > DW'(mlen))) begin
          bad_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          bad_nxt    = 1'b0;
          minute_nxt = tmin_rem[NW-1:0];
          thr_nxt    = TW'(hour_r) + TW'(ahours_r) + TW'(mcarry);
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        // total hours over 8 times the reciprocal of 3
        prod_nxt  = mul_p;
        state_nxt = S_DAYS;
      end
      S_DAYS: begin
        hour_nxt  = hrem[HW-1:0];
        dday_nxt  = dday_r + DW'(q_day);
        state_nxt = S_WALK;
      end
      S_WALK: begin
        priority if (dday_r <= DW'(mlen)) begin
          state_nxt = S_DONE;
        end else if (skip_400) begin
          dday_nxt = sub_d[DW-1:0];
          if (year_400 > YW'(cdta_pkg::YEAR_MAX)) begin
            year_nxt = year_400 - YW'(cdta_pkg::YEAR_SPAN);
            ovf_nxt  = 1'b1;
          end else begin
            year_nxt = year_400;
          end
        end else if (skip_year) begin
          dday_nxt = sub_d[DW-1:0];
          year_nxt = year_step;
          r25_nxt  = r25_step;
          ovf_nxt  = ovf_step;
        end else begin
          dday_nxt = sub_d[DW-1:0];
          if (month_r == cdta_pkg::MONTH_DEC) begin
            month_nxt = cdta_pkg::MONTH_JAN;
            year_nxt  = year_step;
            r25_nxt   = r25_step;
            ovf_nxt   = ovf_step;
          end else begin
            month_nxt = month_r + MW'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    dday_r   <= dday_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    amin_r   <= amin_nxt;
    ahours_r <= ahours_nxt;
    prod_r   <= prod_nxt;
    r25_r    <= r25_nxt;
    thr_r    <= thr_nxt;
    bad_r    <= bad_nxt;
    ovf_r    <= ovf_nxt;
  end

endmodule

[rtl/cdta_checker.sv]
// ----------------------------------------------------------------------------
// cdta_checker
// Port-level checks for the calendar date and time adder, bound to the top.
// ----------------------------------------------------------------------------
module cdta_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cdta_pkg::YEAR_W-1:0]   out_end_year,
  input logic [cdta_pkg::MONTH_W-1:0]  out_end_month,
  input logic [cdta_pkg::HOUR_W-1:0]   out_end_hour,
  input logic [cdta_pkg::MINUTE_W-1:0] out_end_minute,
  input logic                          out_bad_date,
  input logic                          out_year_overflow
);

  // an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item accepted");

  // no new item while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_end_year) &&
      $stable(out_end_month) && $stable(out_bad_date)))
    else $error("stalled result changed");

  // a bad start date never reports overflow
  a_bad_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_date) |-> !out_year_overflow)
    else $error("overflow flagged on bad date");

  // a good result has a normalized time and month, oversized years may stay
  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_date) |-> ((out_end_minute < 6'd60) &&
      (out_end_hour < 5'd24) && (out_end_month != 4'd0) &&
      (out_end_month < 4'd13)))
    else $error("result not normalized");

endmodule

bind calendar_date_time_adder cdta_checker u_cdta_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_end_year     (out_end_year),
  .out_end_month    (out_end_month),
  .out_end_hour     (out_end_hour),
  .out_end_minute   (out_end_minute),
  .out_bad_date     (out_bad_date),
  .out_year_overflow(out_year_overflow)
);

[dv/date_time_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_time_checker
// Watches both channels of the calendar date and time adder. Every accepted
// start item is turned into its predicted end date and time, queued, and
// compared field by field with the next result that leaves the block.
// ----------------------------------------------------------------------------
module date_time_checker #(
  parameter int HOURS_WIDTH = cdta_pkg::HOURS_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [cdta_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [cdta_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [cdta_pkg::DAY_W-1:0]    in_start_day,
  input  logic [cdta_pkg::HOUR_W-1:0]   in_start_hour,
  input  logic [cdta_pkg::MINUTE_W-1:0] in_start_minute,
  input  logic [cdta_pkg::MINUTE_W-1:0] in_add_minutes,
  input  logic [HOURS_WIDTH-1:0]        in_add_hours,
  // result channel
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [cdta_pkg::YEAR_W-1:0]   out_end_year,
  input  logic [cdta_pkg::MONTH_W-1:0]  out_end_month,
  input  logic [cdta_pkg::DAY_W-1:0]    out_end_day,
  input  logic [cdta_pkg::HOUR_W-1:0]   out_end_hour,
  input  logic [cdta_pkg::MINUTE_W-1:0] out_end_minute,
  input  logic                          out_bad_date,
  input  logic                          out_year_overflow,
  // run control and status
  input  logic                          end_of_test,
  output int                            mismatch_count,
  output int                            pending_results,
  output int                            results_checked,
  output int                            bad_seen,
  output int                            wrap_seen
);

  localparam int MAX_PRINTED = 30;
  // one bit per month number that has 30 days: april, june, september, november
  localparam logic [15:0] THIRTY_DAY_MONTHS = 16'h0A50;

  typedef struct {
    logic [cdta_pkg::YEAR_W-1:0]   year;
    logic [cdta_pkg::MONTH_W-1:0]  month;
    logic [cdta_pkg::DAY_W-1:0]    day;
    logic [cdta_pkg::HOUR_W-1:0]   hour;
    logic [cdta_pkg::MINUTE_W-1:0] minute;
    logic [cdta_pkg::MINUTE_W-1:0] add_min;
    logic [HOURS_WIDTH-1:0]        add_hr;
  } start_item_t;

  typedef struct {
    logic [cdta_pkg::YEAR_W-1:0]   year;
    logic [cdta_pkg::MONTH_W-1:0]  month;
    logic [cdta_pkg::DAY_W-1:0]    day;
    logic [cdta_pkg::HOUR_W-1:0]   hour;
    logic [cdta_pkg::MINUTE_W-1:0] minute;
    logic                          bad_date;
    logic                          year_overflow;
  } end_item_t;

  typedef struct {
    start_item_t src;
    end_item_t   want;
  } end_entry_t;

  end_entry_t end_date_q[$];
  logic       leftover_done;

  // gregorian leap rule on the plain year value
  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % cdta_pkg::YEAR_SKIP) == 0;
  endfunction

  // length of a month, zero when the number names no month
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    if (m < cdta_pkg::MONTH_JAN || m > cdta_pkg::MONTH_DEC) return 0;
    if (m == cdta_pkg::MONTH_FEB) return gregorian_leap(y) ? 29 : 28;
    return THIRTY_DAY_MONTHS[m] ? 30 : 31;
  endfunction

  // one year forward, 9999 and anything past it wraps to zero
  function automatic int unsigned year_forward(input int unsigned y, inout bit ovf);
    if (y >= cdta_pkg::YEAR_MAX) begin
      ovf = 1'b1;
      return 0;
    end
    return y + 1;
  endfunction

  // end date and time of one start item
  function automatic end_item_t calc_end_date(input start_item_t it);
    end_item_t       r;
    int unsigned     year, month, hour, minute, tmin, ylen;
    longint unsigned thr, dday;
    bit              ovf;
    year   = it.year;
    month  = it.month;
    hour   = it.hour;
    minute = it.minute;
    dday   = it.day;
    ovf    = 1'b0;
    r.bad_date = 1'b0;
    if (month < cdta_pkg::MONTH_JAN || month > cdta_pkg::MONTH_DEC ||
        dday < 1 || dday > month_days(month, year)) begin
      r.bad_date = 1'b1;
    end else begin
      tmin   = minute + it.add_min;
      thr    = longint'(hour) + longint'(it.add_hr) + longint'(tmin / cdta_pkg::MIN_PER_HOUR);
      minute = tmin % cdta_pkg::MIN_PER_HOUR;
      hour   = int'(thr % cdta_pkg::HOURS_PER_DAY);
      dday   = dday + thr / cdta_pkg::HOURS_PER_DAY;
      while (dday > month_days(month, year)) begin
        ylen = gregorian_leap(year) ? cdta_pkg::DAYS_PER_LEAP : cdta_pkg::DAYS_PER_YEAR;
        if (month == cdta_pkg::MONTH_JAN && year <= cdta_pkg::YEAR_MAX &&
            dday > cdta_pkg::DAYS_PER_400Y) begin
          // whole 400-year cycle from january
          dday = dday - cdta_pkg::DAYS_PER_400Y;
          year = year + cdta_pkg::YEAR_SKIP;
          if (year > cdta_pkg::YEAR_MAX) begin
            year = year - cdta_pkg::YEAR_SPAN;
            ovf  = 1'b1;
          end
        end else if (month == cdta_pkg::MONTH_JAN && year <= cdta_pkg::YEAR_MAX &&
                     dday > ylen) begin
          // whole year from january
          dday = dday - ylen;
          year = year_forward(year, ovf);
        end else begin
          dday  = dday - month_days(month, year);
          month = month + 1;
          if (month > cdta_pkg::MONTH_DEC) begin
            month = cdta_pkg::MONTH_JAN;
            year  = year_forward(year, ovf);
          end
        end
      end
    end
    r.year          = year[cdta_pkg::YEAR_W-1:0];
    r.month         = month[cdta_pkg::MONTH_W-1:0];
    r.day           = dday[cdta_pkg::DAY_W-1:0];
    r.hour          = hour[cdta_pkg::HOUR_W-1:0];
    r.minute        = minute[cdta_pkg::MINUTE_W-1:0];
    r.year_overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input start_item_t src);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d (start %0d-%0d-%0d %0d:%0d + %0dh %0dm)",
                                name, got, want, src.year, src.month, src.day, src.hour,
                                src.minute, src.add_hr, src.add_min));
  endtask

  // channel monitor: queue predictions, compare results in order
  always @(posedge clk) begin
    start_item_t it;
    end_entry_t  e;
    if (!rst_n) begin
      end_date_q.delete();
      mismatch_count  = 0;
      results_checked = 0;
      bad_seen        = 0;
      wrap_seen       = 0;
      leftover_done   <= 1'b0;
      pending_results <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        it.year    = in_start_year;
        it.month   = in_start_month;
        it.day     = in_start_day;
        it.hour    = in_start_hour;
        it.minute  = in_start_minute;
        it.add_min = in_add_minutes;
        it.add_hr  = in_add_hours;
        e.src  = it;
        e.want = calc_end_date(it);
        end_date_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (end_date_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %0d-%0d-%0d %0d:%0d",
                                    out_end_year, out_end_month, out_end_day,
                                    out_end_hour, out_end_minute));
        end else begin
          e = end_date_q.pop_front();
          check_field("end_year", out_end_year, e.want.year, e.src);
          check_field("end_month", out_end_month, e.want.month, e.src);
          check_field("end_day", out_end_day, e.want.day, e.src);
          check_field("end_hour", out_end_hour, e.want.hour, e.src);
          check_field("end_minute", out_end_minute, e.want.minute, e.src);
          check_field("bad_date", out_bad_date, e.want.bad_date, e.src);
          check_field("year_overflow", out_year_overflow, e.want.year_overflow, e.src);
          results_checked++;
          if (e.want.bad_date) bad_seen++;
          if (e.want.year_overflow) wrap_seen++;
        end
      end
      // anything still queued at the end never came out
      if (end_of_test && !leftover_done) begin
        leftover_done <= 1'b1;
        if (end_date_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived", end_date_q.size()));
      end
      pending_results <= end_date_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the calendar date and time adder. Sends a short
// directed set of dates (leap days, bad dates, year wrap, extreme fields)
// and then random dates with bursty idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOURS_W       = cdta_pkg::HOURS_WIDTH_DEF;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int SEGMENTS      = 4;
  localparam int TAIL_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1500000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [cdta_pkg::YEAR_W-1:0]   in_start_year;
  logic [cdta_pkg::MONTH_W-1:0]  in_start_month;
  logic [cdta_pkg::DAY_W-1:0]    in_start_day;
  logic [cdta_pkg::HOUR_W-1:0]   in_start_hour;
  logic [cdta_pkg::MINUTE_W-1:0] in_start_minute;
  logic [cdta_pkg::MINUTE_W-1:0] in_add_minutes;
  logic [HOURS_W-1:0]            in_add_hours;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cdta_pkg::YEAR_W-1:0]   out_end_year;
  logic [cdta_pkg::MONTH_W-1:0]  out_end_month;
  logic [cdta_pkg::DAY_W-1:0]    out_end_day;
  logic [cdta_pkg::HOUR_W-1:0]   out_end_hour;
  logic [cdta_pkg::MINUTE_W-1:0] out_end_minute;
  logic                          out_bad_date;
  logic                          out_year_overflow;

  logic        end_of_test = 1'b0;
  logic        calm_phase  = 1'b1;
  int unsigned stall_hold  = 0;
  int unsigned cycle_count = 0;
  int          mismatch_count;
  int          pending_results;
  int          results_checked;
  int          bad_seen;
  int          wrap_seen;
  int          directed_count;
  int          random_count;

  calendar_date_time_adder #(
    .HOURS_WIDTH(HOURS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_year(in_start_year),
    .in_start_month(in_start_month),
    .in_start_day(in_start_day),
    .in_start_hour(in_start_hour),
    .in_start_minute(in_start_minute),
    .in_add_minutes(in_add_minutes),
    .in_add_hours(in_add_hours),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_end_year(out_end_year),
    .out_end_month(out_end_month),
    .out_end_day(out_end_day),
    .out_end_hour(out_end_hour),
    .out_end_minute(out_end_minute),
    .out_bad_date(out_bad_date),
    .out_year_overflow(out_year_overflow)
  );

  date_time_checker #(
    .HOURS_WIDTH(HOURS_W)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_year(in_start_year),
    .in_start_month(in_start_month),
    .in_start_day(in_start_day),
    .in_start_hour(in_start_hour),
    .in_start_minute(in_start_minute),
    .in_add_minutes(in_add_minutes),
    .in_add_hours(in_add_hours),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_end_year(out_end_year),
    .out_end_month(out_end_month),
    .out_end_day(out_end_day),
    .out_end_hour(out_end_hour),
    .out_end_minute(out_end_minute),
    .out_bad_date(out_bad_date),
    .out_year_overflow(out_year_overflow),
    .end_of_test(end_of_test),
    .mismatch_count(mismatch_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .bad_seen(bad_seen),
    .wrap_seen(wrap_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results);
      $display("Verification failed");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stall pattern, held low during calm stretches
  always @(posedge clk) begin
    int unsigned len;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm_phase) begin
      out_stall <= 1'b0;
    end else begin
      len = pick_gap();
      if (len == 0) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 4);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= len - 1;
      end
    end
  end

  // drive one item, hold it until accepted, then maybe idle
  task automatic send_item(input int unsigned y, input int unsigned mo, input int unsigned d,
                           input int unsigned h, input int unsigned mi, input int unsigned am,
                           input int unsigned ah);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_start_year   <= y[cdta_pkg::YEAR_W-1:0];
    in_start_month  <= mo[cdta_pkg::MONTH_W-1:0];
    in_start_day    <= d[cdta_pkg::DAY_W-1:0];
    in_start_hour   <= h[cdta_pkg::HOUR_W-1:0];
    in_start_minute <= mi[cdta_pkg::MINUTE_W-1:0];
    in_add_minutes  <= am[cdta_pkg::MINUTE_W-1:0];
    in_add_hours    <= ah[HOURS_W-1:0];
    do @(posedge clk); while (in_stall);
    gap = calm_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every queued result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // random start item: mostly well-formed dates, some noise
  task automatic send_random_item();
    int unsigned r, ry, y, mo, d, h, mi, am, ah;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      y  = $urandom_range(0, 16383);
      mo = $urandom_range(0, 15);
      d  = $urandom_range(0, 31);
      h  = $urandom_range(0, 31);
      mi = $urandom_range(0, 63);
      am = $urandom_range(0, 63);
      ah = $urandom_range(0, 65535);
    end else begin
      ry = $urandom_range(0, 99);
      if (ry < 60)      y = $urandom_range(0, cdta_pkg::YEAR_MAX);
      else if (ry < 75) y = $urandom_range(0, 99) * 100 + $urandom_range(0, 4);
      else if (ry < 88) y = $urandom_range(9990, cdta_pkg::YEAR_MAX);
      else              y = $urandom_range(cdta_pkg::YEAR_SPAN, 16383);
      mo = $urandom_range(1, 12);
      // month-end days also produce dates past the end of short months
      d  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 28) : $urandom_range(29, 31);
      h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
      mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      am = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      r  = $urandom_range(0, 99);
      if (r < 30)      ah = $urandom_range(0, 47);
      else if (r < 55) ah = $urandom_range(0, 1000);
      else if (r < 85) ah = $urandom_range(0, 65535);
      else if (r < 92) ah = 65535;
      else             ah = $urandom_range(60000, 65535);
    end
    send_item(y, mo, d, h, mi, am, ah);
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_start_year   = '0;
    in_start_month  = '0;
    in_start_day    = '0;
    in_start_hour   = '0;
    in_start_minute = '0;
    in_add_minutes  = '0;
    in_add_hours    = '0;
    directed_count  = 0;
    random_count    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: leap days, bad dates, wraps and field extremes
    calm_phase <= 1'b0;
    send_item(2024, 2, 29, 12, 30, 0, 0);
    send_item(2023, 2, 29, 0, 0, 0, 0);        // feb 29 in a common year
    send_item(1900, 2, 29, 0, 0, 0, 0);        // century that is not leap
    send_item(2000, 2, 29, 23, 59, 1, 0);      // 400-year leap, rolls into march
    send_item(2024, 0, 10, 5, 5, 5, 5);        // month zero
    send_item(2024, 13, 10, 5, 5, 5, 5);       // month past december
    send_item(2024, 15, 31, 31, 63, 63, 65535);
    send_item(2024, 4, 31, 8, 0, 0, 100);      // day past end of april
    send_item(2024, 6, 0, 8, 0, 0, 100);       // day zero
    send_item(2024, 1, 31, 23, 59, 1, 0);
    send_item(9999, 12, 31, 23, 59, 1, 0);     // last minute of year 9999
    send_item(9999, 1, 1, 0, 0, 0, 65535);
    send_item(16383, 12, 31, 0, 0, 0, 24);     // oversized year steps to zero
    send_item(16383, 2, 29, 0, 0, 0, 0);
    send_item(10400, 2, 29, 10, 0, 0, 300);    // oversized year keeps its own leap rule
    send_item(10400, 12, 31, 0, 0, 0, 24);
    send_item(0, 2, 29, 0, 0, 0, 0);
    send_item(0, 1, 1, 0, 0, 0, 0);
    send_item(1234, 5, 17, 31, 63, 63, 65535); // unflagged hour and minute overrange
    send_item(2023, 12, 31, 23, 0, 0, 1);
    send_item(2020, 1, 1, 0, 0, 59, 8784);     // whole leap year from january
    send_item(9999, 12, 31, 0, 0, 0, 0);
    send_item(16383, 1, 15, 0, 0, 0, 65535);
    send_item(2100, 2, 28, 23, 59, 1, 0);
    directed_count = 24;
    wait_for_drain();

    // random segments, the first one with no idling at all
    for (int s = 0; s < SEGMENTS; s++) begin
      calm_phase <= (s == 0);
      for (int i = 0; i < RANDOM_ITEMS / SEGMENTS; i++) begin
        send_random_item();
        random_count++;
      end
      if (s == 1) wait_for_drain();
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("sent %0d directed and %0d random start items in %0d cycles",
             directed_count, random_count, cycle_count);
    $display("checked %0d results: %0d bad start dates, %0d year wraps, %0d mismatches",
             results_checked, bad_seen, wrap_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cdta_pkg.sv
rtl/calendar_date_time_adder.sv
rtl/cdta_checker.sv
dv/date_time_checker.sv
dv/tb_top.sv
